// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL top level of the rolling-sum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tbrs_pkg.sv =====
// Types and constants of the time-bucketed rolling sum.
`default_nettype none

package tbrs_pkg;

  // Ring depth; must be a power of two.
  localparam int unsigned NUM_BUCKETS = 16;
  localparam int unsigned SLOT_W      = $clog2(NUM_BUCKETS);
  localparam int unsigned FILL_W      = SLOT_W + 1;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned HITS_W = 32;
  localparam int unsigned CNT_W  = 36;
  localparam int unsigned IV_W   = 32;
  localparam int unsigned SMP_W  = 32;

  localparam logic [IV_W-1:0] IV_RESET = IV_W'(1000000);

  // Remainder unit: one numerator bit per step.
  localparam int unsigned DIV_STEPS = TIME_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [SUM_W-1:0]  total;
    logic [HITS_W-1:0] hits;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            entry;
  } ring_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== src/tbrs_if.sv =====
// Handshake channel interfaces: input items, result items, configuration writes.
`default_nettype none

interface tbrs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [tbrs_pkg::TIME_W-1:0]      now_us;
  logic [tbrs_pkg::SMP_W-1:0]       sample;

  modport source (output valid, output func, output now_us, output sample, input ready);
  modport sink   (input valid, input func, input now_us, input sample, output ready);
endinterface

interface tbrs_out_if;
  logic                             valid;
  logic                             ready;
  logic [tbrs_pkg::SUM_W-1:0]       window_sum;
  logic [tbrs_pkg::CNT_W-1:0]       window_count;
  logic [tbrs_pkg::TIME_W-1:0]      covered_span;

  modport source (output valid, output window_sum, output window_count,
                  output covered_span, input ready);
  modport sink   (input valid, input window_sum, input window_count,
                  input covered_span, output ready);
endinterface

interface tbrs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tbrs_pkg::IV_W-1:0]        bucket_interval;

  modport source (output valid, output bucket_interval, input ready);
  modport sink   (input valid, input bucket_interval, output ready);
endinterface

`default_nettype wire

// ===== src/tbrs_div.sv =====
// Bit-serial restoring remainder unit: num mod den, one numerator bit per cycle.
`default_nettype none

module tbrs_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [tbrs_pkg::TIME_W-1:0]     num_i,
  input  wire logic [tbrs_pkg::IV_W-1:0]       den_i,
  output tbrs_pkg::div_stat_t                  stat_o,
  output logic      [tbrs_pkg::IV_W-1:0]       rem_o
);

  logic [tbrs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [tbrs_pkg::TIME_W-1:0]    num_q, num_d;
  logic [tbrs_pkg::IV_W-1:0]      den_q, den_d;
  logic [tbrs_pkg::IV_W-1:0]      rem_q, rem_d;

  logic [tbrs_pkg::IV_W:0]        rem_sh;
  logic [tbrs_pkg::IV_W+1:0]      diff;

  // Partial remainder stays below den, so the shifted value fits IV_W+1 bits.
  assign rem_sh = {rem_q, num_q[tbrs_pkg::TIME_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = tbrs_pkg::DIV_CNT_W'(tbrs_pkg::DIV_STEPS);
      busy_d = 1'b1;
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[tbrs_pkg::TIME_W-2:0], 1'b0};
      rem_d = diff[tbrs_pkg::IV_W+1] ? rem_sh[tbrs_pkg::IV_W-1:0]
                                     : diff[tbrs_pkg::IV_W-1:0];
      cnt_d = cnt_q - tbrs_pkg::DIV_CNT_W'(1);
      if (cnt_q == tbrs_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

// ===== src/tbrs_ring.sv =====
// Bucket ring storage: one write port, one registered read port.
`default_nettype none

module tbrs_ring (
  input  wire logic                            clk_i,
  input  tbrs_pkg::ring_wr_t                   wr_i,
  input  wire logic [tbrs_pkg::SLOT_W-1:0]     rd_addr_i,
  output tbrs_pkg::entry_t                     rd_o
);

  tbrs_pkg::entry_t mem [tbrs_pkg::NUM_BUCKETS];
  tbrs_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

// ===== src/time_bucketed_rolling_sum.sv =====
// Top level of the time-bucketed rolling sum: sequencer, bookkeeping and output register.
`default_nettype none

// Sliding-window counter over a ring of 16 time buckets (start, sum, hit count).
// An add item (func 0) rounds now_us down to a multiple of bucket_interval
// (an interval of 0 behaves as 1), opens a fresh bucket if the ring is empty or
// the newest bucket starts elsewhere (the oldest is overwritten once all 16 are
// in use), and adds the sample; it yields no result. A query item (func 1)
// yields one result: the wrapping sum and 36-bit count over every bucket whose
// start is at or after now_us - 16 * interval (floored at 0), plus now_us minus
// the oldest bucket start modulo 2^48, or 0 when no bucket exists yet.
// Flow: one item at a time, in_i.ready is low while it is worked on. An add
// is worked on by the bit-serial remainder unit (48 steps, one per bit of
// now_us), then by the bucket update. A query walks the F filled buckets
// (0..16) in order from the oldest, each through a read state and an
// accumulate state on the single ring read port. Results sit in an output
// register, so a stalled out_o consumer only blocks once a second query result
// is ready. No clearing pass after reset: bucket contents are only read once
// written. cfg_i is always ready; write it only while no item is in flight.
module time_bucketed_rolling_sum (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tbrs_in_if.sink        in_i,
  tbrs_cfg_if.sink       cfg_i,
  tbrs_out_if.source     out_o
);

  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_Q_RD  = 3'd3;
  localparam logic [2:0] ST_Q_ACC = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int unsigned SLOT_W = tbrs_pkg::SLOT_W;
  localparam int unsigned FILL_W = tbrs_pkg::FILL_W;
  localparam int unsigned TIME_W = tbrs_pkg::TIME_W;
  localparam int unsigned SUM_W  = tbrs_pkg::SUM_W;
  localparam int unsigned CNT_W  = tbrs_pkg::CNT_W;
  localparam int unsigned HITS_W = tbrs_pkg::HITS_W;
  localparam int unsigned IV_W   = tbrs_pkg::IV_W;

  logic [2:0]        state_q, state_d;
  logic [IV_W-1:0]   iv_q;
  logic [SLOT_W-1:0] newest_q, newest_d;
  logic [FILL_W-1:0] filled_q, filled_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [FILL_W-1:0] left_q, left_d;
  logic              first_q, first_d;
  logic              out_valid_q, out_valid_d;

  logic [TIME_W-1:0]       now_q, now_d;
  logic [tbrs_pkg::SMP_W-1:0] sample_q, sample_d;
  logic [TIME_W-1:0]       begin_q, begin_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [TIME_W-1:0]       span_q, span_d;
  logic [SUM_W-1:0]        osum_q, osum_d;
  logic [CNT_W-1:0]        ocnt_q, ocnt_d;
  logic [TIME_W-1:0]       ospan_q, ospan_d;

  logic [IV_W-1:0]   iv_eff;
  logic [TIME_W-1:0] range_w;
  logic [TIME_W-1:0] t_round;
  logic              in_acc;
  logic              out_acc;
  logic              new_bucket;
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W-1:0] rd_addr;

  tbrs_pkg::div_stat_t div_stat;
  logic [IV_W-1:0]     div_rem;
  logic                div_start;
  tbrs_pkg::entry_t    rd_entry;
  tbrs_pkg::ring_wr_t  ring_wr;

  // Zero interval acts as one.
  assign iv_eff  = (iv_q == '0) ? IV_W'(1) : iv_q;
  // Window length = interval * NUM_BUCKETS, a plain shift.
  assign range_w = TIME_W'(iv_eff) << SLOT_W;
  assign t_round = now_q - TIME_W'(div_rem);

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign div_start = in_acc && (in_i.func == tbrs_pkg::FUNC_ADD);

  // Oldest filled slot; with a full ring it is the one after the newest.
  assign oldest  = newest_q + SLOT_W'(1) - filled_q[SLOT_W-1:0];
  // Newest slot is addressed while adding, the walk index while querying.
  assign rd_addr = (state_q == ST_Q_RD || state_q == ST_Q_ACC) ? idx_q : newest_q;

  assign new_bucket = (filled_q == '0) || (rd_entry.start != t_round);

  always_comb begin
    ring_wr             = '0;
    ring_wr.en          = (state_q == ST_ADD);
    if (new_bucket) begin
      ring_wr.addr        = newest_q + SLOT_W'(1);
      ring_wr.entry.start = t_round;
      ring_wr.entry.total = SUM_W'(sample_q);
      ring_wr.entry.hits  = HITS_W'(1);
    end else begin
      ring_wr.addr        = newest_q;
      ring_wr.entry.start = rd_entry.start;
      ring_wr.entry.total = rd_entry.total + SUM_W'(sample_q);
      ring_wr.entry.hits  = rd_entry.hits + HITS_W'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    newest_d    = newest_q;
    filled_d    = filled_q;
    idx_d       = idx_q;
    left_d      = left_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    now_d       = now_q;
    sample_d    = sample_q;
    begin_d     = begin_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    span_d      = span_q;
    osum_d      = osum_q;
    ocnt_d      = ocnt_q;
    ospan_d     = ospan_q;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          now_d    = in_i.now_us;
          sample_d = in_i.sample;
          if (in_i.func == tbrs_pkg::FUNC_ADD) begin
            state_d = ST_DIV;
          end else begin
            begin_d = (in_i.now_us >= range_w) ? in_i.now_us - range_w : '0;
            idx_d   = oldest;
            left_d  = filled_q;
            first_d = 1'b1;
            sum_d   = '0;
            cnt_d   = '0;
            span_d  = '0;
            state_d = (filled_q == '0) ? ST_DONE : ST_Q_RD;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (new_bucket) begin
          newest_d = newest_q + SLOT_W'(1);
          if (filled_q < FILL_W'(tbrs_pkg::NUM_BUCKETS)) begin
            filled_d = filled_q + FILL_W'(1);
          end
        end
        state_d = ST_IDLE;
      end
      ST_Q_RD: begin
        // Ring read data lands at the end of this cycle.
        state_d = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        if (first_q) begin
          span_d = now_q - rd_entry.start;
        end
        if (rd_entry.start >= begin_q) begin
          sum_d = sum_q + rd_entry.total;
          cnt_d = cnt_q + CNT_W'(rd_entry.hits);
        end
        first_d = 1'b0;
        idx_d   = idx_q + SLOT_W'(1);
        left_d  = left_q - FILL_W'(1);
        state_d = (left_q == FILL_W'(1)) ? ST_DONE : ST_Q_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          osum_d      = sum_q;
          ocnt_d      = cnt_q;
          ospan_d     = span_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iv_q        <= tbrs_pkg::IV_RESET;
      newest_q    <= '0;
      filled_q    <= '0;
      idx_q       <= '0;
      left_q      <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      filled_q    <= filled_d;
      idx_q       <= idx_d;
      left_q      <= left_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        iv_q <= cfg_i.bucket_interval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    sample_q <= sample_d;
    begin_q  <= begin_d;
    sum_q    <= sum_d;
    cnt_q    <= cnt_d;
    span_q   <= span_d;
    osum_q   <= osum_d;
    ocnt_q   <= ocnt_d;
    ospan_q  <= ospan_d;
  end

  tbrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (in_i.now_us),
    .den_i   (iv_eff),
    .stat_o  (div_stat),
    .rem_o   (div_rem)
  );

  tbrs_ring u_ring (
    .clk_i     (clk_i),
    .wr_i      (ring_wr),
    .rd_addr_i (rd_addr),
    .rd_o      (rd_entry)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.window_sum   = osum_q;
  assign out_o.window_count = ocnt_q;
  assign out_o.covered_span = ospan_q;

  `TBRS_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1,
                   filled_q <= FILL_W'(tbrs_pkg::NUM_BUCKETS),
                   "fill count beyond ring depth")
  `TBRS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_i.ready,
                   "item accepted while previous in flight")
  `TBRS_ASSERT_IMP(a_result_from_query, clk_i, rst_ni, $rose(out_valid_q),
                   $past(state_q) == ST_DONE, "result raised outside query completion")
  `TBRS_ASSERT_IMP(a_rem_below_den, clk_i, rst_ni, div_stat.done, div_rem < iv_eff,
                   "remainder not below bucket interval")
  `TBRS_ASSERT_IMP(a_div_only_in_step, clk_i, rst_ni, div_stat.busy, state_q == ST_DIV,
                   "remainder unit busy outside the divide step")

endmodule

`default_nettype wire

// ===== dv/rolling_sum_checker.sv =====
// Watches the rolling-sum channels, predicts each query result and compares it.
`timescale 1ns / 1ps

module rolling_sum_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbrs_in_if          in_mon,
  tbrs_cfg_if         cfg_mon,
  tbrs_out_if         out_mon,
  output int unsigned mismatches_o,
  output int unsigned awaiting_o
);

  localparam int unsigned NUM_BUCKETS = tbrs_pkg::NUM_BUCKETS;
  localparam int unsigned SLOT_W      = tbrs_pkg::SLOT_W;
  localparam int unsigned FILL_W      = tbrs_pkg::FILL_W;
  localparam int unsigned TIME_W      = tbrs_pkg::TIME_W;
  localparam int unsigned SUM_W       = tbrs_pkg::SUM_W;
  localparam int unsigned HITS_W      = tbrs_pkg::HITS_W;
  localparam int unsigned CNT_W       = tbrs_pkg::CNT_W;
  localparam int unsigned IV_W        = tbrs_pkg::IV_W;
  localparam int unsigned SMP_W       = tbrs_pkg::SMP_W;

  typedef struct packed {
    logic [SUM_W-1:0]  total_sum;
    logic [CNT_W-1:0]  hit_count;
    logic [TIME_W-1:0] span;
  } window_t;

  // Shadow ring.
  logic [TIME_W-1:0] slot_start [NUM_BUCKETS];
  logic [SUM_W-1:0]  slot_total [NUM_BUCKETS];
  logic [HITS_W-1:0] slot_hits  [NUM_BUCKETS];
  logic [SLOT_W-1:0] newest;
  logic [FILL_W-1:0] filled;
  logic [IV_W-1:0]   width_q = tbrs_pkg::IV_RESET;

  window_t     expected_windows [$];
  window_t     got, want;
  int unsigned mismatch_total = 0;

  assign mismatches_o = mismatch_total;

  // Zero width behaves as one.
  function automatic logic [63:0] bucket_width();
    return (width_q == '0) ? 64'd1 : {32'd0, width_q};
  endfunction

  function automatic void fold_sample(input logic [TIME_W-1:0] now,
                                      input logic [SMP_W-1:0] val);
    logic [63:0] w, base;
    w    = bucket_width();
    base = ({16'd0, now} / w) * w;
    if (filled == '0 || slot_start[newest] != base[TIME_W-1:0]) begin
      newest = newest + SLOT_W'(1);
      if (filled < FILL_W'(NUM_BUCKETS)) filled = filled + FILL_W'(1);
      slot_start[newest] = base[TIME_W-1:0];
      slot_total[newest] = '0;
      slot_hits[newest]  = '0;
    end
    slot_total[newest] = slot_total[newest] + {32'd0, val};
    slot_hits[newest]  = slot_hits[newest] + HITS_W'(1);
  endfunction

  function automatic window_t predict_window(input logic [TIME_W-1:0] now);
    logic [63:0]       reach, floor_t;
    logic [SLOT_W-1:0] idx;
    window_t           r;
    reach   = bucket_width() * 64'(NUM_BUCKETS);
    floor_t = ({16'd0, now} >= reach) ? {16'd0, now} - reach : 64'd0;
    // oldest filled slot
    idx = newest - SLOT_W'(filled) + SLOT_W'(1);
    r   = '0;
    if (filled != '0) r.span = now - slot_start[idx];
    for (int unsigned k = 0; k < filled; k++) begin
      if ({16'd0, slot_start[idx]} >= floor_t) begin
        r.total_sum = r.total_sum + slot_total[idx];
        r.hit_count = r.hit_count + CNT_W'(slot_hits[idx]);
      end
      idx = idx + SLOT_W'(1);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, seen, wanted);
    mismatch_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        slot_start[i] = '0;
        slot_total[i] = '0;
        slot_hits[i]  = '0;
      end
      newest  = '0;
      filled  = '0;
      width_q = tbrs_pkg::IV_RESET;
      expected_windows.delete();
      awaiting_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) width_q = cfg_mon.bucket_interval;

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.func == tbrs_pkg::FUNC_ADD) fold_sample(in_mon.now_us, in_mon.sample);
        else expected_windows.push_back(predict_window(in_mon.now_us));
      end

      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.window_sum, out_mon.window_count, out_mon.covered_span};
        if (expected_windows.size() == 0) begin
          report_mismatch("result with nothing pending, sum", got.total_sum, '0);
        end else begin
          want = expected_windows.pop_front();
          if (got.total_sum != want.total_sum)
            report_mismatch("window_sum", got.total_sum, want.total_sum);
          if (got.hit_count != want.hit_count)
            report_mismatch("window_count", 64'(got.hit_count), 64'(want.hit_count));
          if (got.span != want.span)
            report_mismatch("covered_span", 64'(got.span), 64'(want.span));
        end
      end

      awaiting_o <= expected_windows.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Stimulus, handshake pacing and verdict for the time-bucketed rolling sum.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IV_W   = tbrs_pkg::IV_W;
  localparam int unsigned TIME_W = tbrs_pkg::TIME_W;
  localparam int unsigned SMP_W  = tbrs_pkg::SMP_W;

  localparam int unsigned MAX_WAIT      = 19;    // longest idle draw per item
  localparam int unsigned SETTLE_CYCLES = 64;    // room for the tail of a trailing add
  localparam int unsigned IDLE_LIMIT    = 2000;  // cycles without any handshake
  localparam int unsigned PHASE_ITEMS   = 165;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  tbrs_in_if  in_ch ();
  tbrs_out_if out_ch ();
  tbrs_cfg_if cfg_ch ();

  time_bucketed_rolling_sum dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  int unsigned mismatch_count;
  int unsigned awaiting;

  rolling_sum_checker window_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .cfg_mon      (cfg_ch),
    .out_mon      (out_ch),
    .mismatches_o (mismatch_count),
    .awaiting_o   (awaiting)
  );

  // Calm stretches: while set, that side never idles.
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;

  function automatic int unsigned pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // ---------------------------------------------------------------------------
  // Result consumer: after each accepted result, hold ready low for a random
  // number of cycles (zero keeps it high, so back-to-back results go through).
  // ---------------------------------------------------------------------------
  logic        sink_ready = 1'b0;
  int unsigned sink_hold  = 0;
  int unsigned sink_draw;

  assign out_ch.ready = sink_ready;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      sink_hold  <= 0;
    end else if (out_ch.valid && sink_ready) begin
      if ($urandom_range(0, 39) == 0) sink_calm = ~sink_calm;
      sink_draw = pick_wait(sink_calm);
      sink_hold  <= sink_draw;
      sink_ready <= (sink_draw == 0);
    end else if (sink_hold != 0) begin
      sink_hold  <= sink_hold - 1;
      sink_ready <= (sink_hold == 1);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on any channel restarts the count.
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, awaiting);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int unsigned       add_items   = 0;
  int unsigned       query_items = 0;
  int unsigned       width_loads = 0;
  logic [IV_W-1:0]   width_now   = tbrs_pkg::IV_RESET;  // mirrors the register for pacing time
  logic [TIME_W-1:0] clock_us    = '0;                  // running add time

  // One input item; valid stays high across items when no gap is drawn.
  task automatic send_item(input logic func, input logic [TIME_W-1:0] now,
                           input logic [SMP_W-1:0] val);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_calm = ~src_calm;
    gap = pick_wait(src_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= func;
    in_ch.now_us <= now;
    in_ch.sample <= val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (func == tbrs_pkg::FUNC_ADD) add_items++;
    else query_items++;
  endtask

  // Lets every pending result out, then the tail of a trailing add.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_width(input logic [IV_W-1:0] w);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.bucket_interval <= w;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    width_now = w;
    width_loads++;
  endtask

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-paced time (same bucket, next buckets, past the window edge),
  // with occasional backward steps and wild jumps across the whole 48-bit range.
  task automatic random_phase(input int unsigned n);
    logic [63:0] w, qt, base;
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      w = (width_now == '0) ? 64'd1 : {32'd0, width_now};
      if ($urandom_range(0, 99) < 62) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      ;  // same time, same bucket
        else if (pick < 55) clock_us = clock_us + TIME_W'({32'd0, $urandom} % w);
        else if (pick < 75) clock_us = clock_us + TIME_W'(w * $urandom_range(1, 3));
        else if (pick < 88) clock_us = clock_us + TIME_W'(w * $urandom_range(4, 24));
        else if (pick < 93)  // time running backwards
          clock_us = clock_us - TIME_W'(({32'd0, $urandom} % (2 * w)) + 1);
        else if (pick < 97) clock_us = TIME_W'({$urandom, $urandom});
        else clock_us = '1 - TIME_W'({32'd0, $urandom} % (4 * w));
        send_item(tbrs_pkg::FUNC_ADD, clock_us, pick_sample());
      end else begin
        // Queries probe the window's lower edge around bucket boundaries.
        base = {16'd0, clock_us} - ({16'd0, clock_us} % w);
        qt   = base + w * $urandom_range(0, 17);
        case ($urandom_range(0, 4))
          0: qt = qt - 1;
          1: ;
          2: qt = qt + 1;
          3: qt = qt + ({32'd0, $urandom} % w);
          default: qt = {$urandom, $urandom};
        endcase
        send_item(tbrs_pkg::FUNC_QUERY, TIME_W'(qt), $urandom);
      end
    end
  endtask

  logic [IV_W-1:0] phase_widths [6];

  initial begin
    in_ch.valid            <= 1'b0;
    in_ch.func             <= tbrs_pkg::FUNC_ADD;
    in_ch.now_us           <= '0;
    in_ch.sample           <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.bucket_interval <= '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset width of one second.
    send_item(tbrs_pkg::FUNC_QUERY, 48'd0, '1);          // empty ring: all zero
    send_item(tbrs_pkg::FUNC_ADD, 48'd0, 32'd0);         // first bucket at time zero
    send_item(tbrs_pkg::FUNC_ADD, 48'd999999, '1);       // same bucket, max sample
    send_item(tbrs_pkg::FUNC_QUERY, 48'd999999, '0);
    send_item(tbrs_pkg::FUNC_ADD, 48'd1000000, 32'd1);   // next bucket
    send_item(tbrs_pkg::FUNC_QUERY, 48'd16000000, '0);   // oldest bucket exactly on the edge
    send_item(tbrs_pkg::FUNC_QUERY, 48'd16000001, '0);   // ...and just outside
    for (int unsigned i = 2; i < 14; i++)
      send_item(tbrs_pkg::FUNC_ADD, TIME_W'(64'(i) * 1000000), 32'h8000_0000 | i);
    send_item(tbrs_pkg::FUNC_QUERY, 48'd13500000, '0);
    send_item(tbrs_pkg::FUNC_ADD, '1, '1);               // top of the time range
    send_item(tbrs_pkg::FUNC_QUERY, '1, '0);
    send_item(tbrs_pkg::FUNC_QUERY, 48'd0, '0);          // going backwards: oldest bucket starts at zero
    send_item(tbrs_pkg::FUNC_ADD, 48'd5, 32'h5A5A_A5A5); // backward add opens a bucket
    send_item(tbrs_pkg::FUNC_QUERY, 48'd5, '0);
    clock_us = 48'd5;

    // Random phases, each under its own bucket width.
    phase_widths[0] = 32'd1;
    phase_widths[1] = 32'd0;                       // behaves as one
    phase_widths[2] = '1;
    phase_widths[3] = tbrs_pkg::IV_RESET;
    phase_widths[4] = $urandom_range(2, 5000);
    phase_widths[5] = $urandom;
    foreach (phase_widths[p]) begin
      settle();
      load_width(phase_widths[p]);
      random_phase(PHASE_ITEMS);
    end
    settle();

    $display("Ran %0d adds and %0d queries across %0d bucket-width loads,",
             add_items, query_items, width_loads);
    $display("including widths of zero, one and all ones, with both sides stalling.");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
